/* sv/rbe_pkg.sv */
// Package for the rigid body Euler step unit: sizes, codes, state and command types.
// Shared by the controller, datapath, divider and top level; depends on nothing.
`default_nettype none
package rbe_pkg;

    localparam int MAX_BODIES = 8;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int DIV_STEPS  = 32 + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int SCALE_W    = 64 - FRAC_BITS;

    localparam logic [30:0] TIME_STEP_RST  = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [30:0] BOX_WIDTH_RST  = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] BOX_HEIGHT_RST = 31'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_FORCE = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_NONE  = 2'd3
    } rbe_mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_LOADED = 2'd2,
        ST_RSVD       = 2'd3
    } rbe_status_t;

    typedef enum logic [1:0] {
        REG_TIME_STEP  = 2'd0,
        REG_BOX_WIDTH  = 2'd1,
        REG_BOX_HEIGHT = 2'd2,
        REG_UNUSED     = 2'd3
    } rbe_reg_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_ADD,
        CS_FORCE,
        CS_EMIT,
        CS_I_LOAD,
        CS_I_CHK,
        CS_I_DIV,
        CS_I_MAX,
        CS_I_MAY,
        CS_I_MVX,
        CS_I_MVY,
        CS_I_PY,
        CS_I_WB,
        CS_P_LOADI,
        CS_P_LOADJ,
        CS_P_TEST
    } rbe_state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CAPTURE,
        DP_ADD,
        DP_FORCE,
        DP_LOAD,
        DP_DIV,
        DP_MAX,
        DP_MAY,
        DP_MVX,
        DP_MVY,
        DP_PY,
        DP_WB,
        DP_LOADI
    } rbe_op_t;

    typedef struct packed {
        rbe_op_t          op;
        logic [IDX_W-1:0] idx;
    } rbe_cmd_t;

    typedef struct packed {
        logic mass_pos;
        logic div_done;
        logic hit;
    } rbe_stat_t;

    // Saturate a 48-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Product with dt divided by 2^FRAC_BITS, truncated toward zero.
    function automatic logic signed [47:0] scale(input logic signed [63:0] p);
        logic signed [63:0] b;
        b = p + (p[63] ? 64'sd0 + ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
        return 48'(b >>> FRAC_BITS);
    endfunction

endpackage
`default_nettype wire

/* sv/rigid_body_euler_step_aabb_unit.sv */
// Rigid body stepper: semi-implicit Euler integration and box overlap report.
// Add / force: item captured, written to the body store, then its result emitted; store
//   full, unloaded index and unused mode go from capture straight to the result.
// Step: each body is loaded, and one with positive mass is divided and updated; then each pair
//   is tested; hits and the closing result wait on output stalls; an empty store just closes.
// One item at a time. Reset (rst_n, async low): no bodies, output empty, dt 0.1, box 1x1.
`default_nettype none
module rigid_body_euler_step_aabb_unit
    import rbe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [2:0] body_index, [34:3] value_x, [66:35] value_y, [98:67] body_mass, [103:99] zero
    input  wire logic [103:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] first_body, [5:3] second_body, [7:6] zero
    output logic [7:0]        m_tdata,
    // [1:0] status, [2] pair_valid
    output logic [2:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    rbe_cmd_t   cmd;
    rbe_stat_t  stat;
    logic [1:0] out_status;
    logic       out_pair;
    logic [2:0] out_first;
    logic [2:0] out_second;

    // Configuration writes land at once; they are to be issued only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    rbe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_idx     (s_tdata[2:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_pair   (out_pair),
        .out_first  (out_first),
        .out_second (out_second),
        .out_last   (m_tlast)
    );

    rbe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_x      (s_tdata[34:3]),
        .in_y      (s_tdata[66:35]),
        .in_mass   (s_tdata[98:67]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data)
    );

    // Pack the result transaction.
    assign m_tdata = {2'b00, out_second, out_first};
    assign m_tuser = {out_pair, out_status};

endmodule
`default_nettype wire

/* sv/rbe_div.sv */
// Restoring divider, one quotient bit per cycle: (force * 2^FRAC_BITS) / mass, saturated.
// Uses rbe_pkg.
`default_nettype none
module rbe_div
    import rbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic        [30:0] divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0] num_reg, num_next;
    logic [30:0]          rem_reg, rem_next;
    logic [30:0]          dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          mag;
    logic [31:0]          shifted;
    logic                 qbit;

    always_comb
    begin
        mag      = dividend[31] ? (~dividend + 32'd1) : dividend;
        shifted  = {rem_reg, num_reg[DIV_STEPS-1]};
        qbit     = (shifted >= {1'b0, dvs_reg});
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            num_next = {mag, {FRAC_BITS{1'b0}}};
            rem_next = '0;
            dvs_next = divisor;
            neg_next = dividend[31];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            rem_next = qbit ? 31'(shifted - {1'b0, dvs_reg}) : shifted[30:0];
            num_next = {num_reg[DIV_STEPS-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done = (cnt_reg == '0);

    always_comb
    begin
        if (!neg_reg)
            quotient = (num_reg[DIV_STEPS-1:31] != '0) ? 32'sh7FFF_FFFF : num_reg[31:0];
        else if ((num_reg[DIV_STEPS-1:32] != '0) || (num_reg[31] && (num_reg[30:0] != '0)))
            quotient = 32'sh8000_0000;
        else
            quotient = ~num_reg[31:0] + 32'd1;
    end

endmodule
`default_nettype wire

/* sv/rbe_datapath.sv */
// Datapath: body stores, configuration registers, work registers, dt multiplier, overlap test.
// Uses rbe_pkg and two rbe_div instances.
`default_nettype none
module rbe_datapath
    import rbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rbe_cmd_t           cmd,
    output rbe_stat_t               stat,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_mass,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_sel,
    input  wire logic [30:0]        cfg_value
);

    logic signed [31:0] pos_x_mem [MAX_BODIES];
    logic signed [31:0] pos_y_mem [MAX_BODIES];
    logic signed [31:0] vel_x_mem [MAX_BODIES];
    logic signed [31:0] vel_y_mem [MAX_BODIES];
    logic signed [31:0] frc_x_mem [MAX_BODIES];
    logic signed [31:0] frc_y_mem [MAX_BODIES];
    logic signed [31:0] mass_mem  [MAX_BODIES];

    logic [30:0] dt_reg, box_w_reg, box_h_reg;

    logic signed [31:0] in_x_reg, in_y_reg, in_m_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, fx_reg, fy_reg, m_reg;
    logic signed [31:0] xi_reg, yi_reg;
    logic signed [63:0] prod_reg;

    logic signed [31:0] ax, ay;
    logic               ax_done, ay_done;
    logic signed [31:0] mul_a;
    logic signed [31:0] step_sum;
    logic signed [31:0] frc_x_sum, frc_y_sum;
    logic signed [33:0] xi_e, xj_e, yi_e, yj_e, w_e, h_e;

    rbe_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_DIV),
        .dividend (fx_reg),
        .divisor  (m_reg[30:0]),
        .done     (ax_done),
        .quotient (ax)
    );

    rbe_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_DIV),
        .dividend (fy_reg),
        .divisor  (m_reg[30:0]),
        .done     (ay_done),
        .quotient (ay)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg    <= TIME_STEP_RST;
            box_w_reg <= BOX_WIDTH_RST;
            box_h_reg <= BOX_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (rbe_reg_t'(cfg_sel))
                REG_TIME_STEP:  dt_reg    <= cfg_value;
                REG_BOX_WIDTH:  box_w_reg <= cfg_value;
                REG_BOX_HEIGHT: box_h_reg <= cfg_value;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.op)
            DP_MAX:  mul_a = ax;
            DP_MAY:  mul_a = ay;
            DP_MVX:  mul_a = vx_reg;
            default: mul_a = vy_reg;
        endcase
        case (cmd.op)
            DP_MAY:  step_sum = sat32(48'(vx_reg) + scale(prod_reg));
            DP_MVX:  step_sum = sat32(48'(vy_reg) + scale(prod_reg));
            DP_MVY:  step_sum = sat32(48'(px_reg) + scale(prod_reg));
            default: step_sum = sat32(48'(py_reg) + scale(prod_reg));
        endcase
        frc_x_sum = sat32(48'(frc_x_mem[cmd.idx]) + 48'(in_x_reg));
        frc_y_sum = sat32(48'(frc_y_mem[cmd.idx]) + 48'(in_y_reg));
    end

    // Work registers and multiplier pipeline.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_CAPTURE:
            begin
                in_x_reg <= in_x;
                in_y_reg <= in_y;
                in_m_reg <= in_mass;
            end
            DP_LOAD:
            begin
                px_reg <= pos_x_mem[cmd.idx];
                py_reg <= pos_y_mem[cmd.idx];
                vx_reg <= vel_x_mem[cmd.idx];
                vy_reg <= vel_y_mem[cmd.idx];
                fx_reg <= frc_x_mem[cmd.idx];
                fy_reg <= frc_y_mem[cmd.idx];
                m_reg  <= mass_mem[cmd.idx];
            end
            DP_LOADI:
            begin
                xi_reg <= pos_x_mem[cmd.idx];
                yi_reg <= pos_y_mem[cmd.idx];
            end
            DP_MAX:  prod_reg <= mul_a * $signed({1'b0, dt_reg});
            DP_MAY:
            begin
                prod_reg <= mul_a * $signed({1'b0, dt_reg});
                vx_reg   <= step_sum;
            end
            DP_MVX:
            begin
                prod_reg <= mul_a * $signed({1'b0, dt_reg});
                vy_reg   <= step_sum;
            end
            DP_MVY:
            begin
                prod_reg <= mul_a * $signed({1'b0, dt_reg});
                px_reg   <= step_sum;
            end
            DP_PY:   py_reg <= step_sum;
            default: ;
        endcase
    end

    // Body stores.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_ADD:
            begin
                pos_x_mem[cmd.idx] <= in_x_reg;
                pos_y_mem[cmd.idx] <= in_y_reg;
                vel_x_mem[cmd.idx] <= '0;
                vel_y_mem[cmd.idx] <= '0;
                frc_x_mem[cmd.idx] <= '0;
                frc_y_mem[cmd.idx] <= '0;
                mass_mem[cmd.idx]  <= in_m_reg;
            end
            DP_FORCE:
            begin
                frc_x_mem[cmd.idx] <= frc_x_sum;
                frc_y_mem[cmd.idx] <= frc_y_sum;
            end
            DP_WB:
            begin
                pos_x_mem[cmd.idx] <= px_reg;
                pos_y_mem[cmd.idx] <= py_reg;
                vel_x_mem[cmd.idx] <= vx_reg;
                vel_y_mem[cmd.idx] <= vy_reg;
                frc_x_mem[cmd.idx] <= '0;
                frc_y_mem[cmd.idx] <= '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        xi_e = 34'(xi_reg);
        yi_e = 34'(yi_reg);
        xj_e = 34'(px_reg);
        yj_e = 34'(py_reg);
        w_e  = $signed({3'b000, box_w_reg});
        h_e  = $signed({3'b000, box_h_reg});
        stat.hit      = (xi_e < xj_e + w_e) && (xi_e + w_e > xj_e)
                     && (yi_e < yj_e + h_e) && (yi_e + h_e > yj_e);
        stat.mass_pos = !m_reg[31] && (m_reg != '0);
        stat.div_done = ax_done && ay_done;
    end

endmodule
`default_nettype wire

/* sv/rbe_ctrl.sv */
// Controller: sequences add, force and step transactions, holds the body count and result register.
// Uses rbe_pkg; drives rbe_datapath through rbe_cmd_t.
`default_nettype none
module rbe_ctrl
    import rbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_mode,
    input  wire logic [2:0] in_idx,
    output rbe_cmd_t        cmd,
    input  wire rbe_stat_t  stat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      out_status,
    output logic            out_pair,
    output logic [2:0]      out_first,
    output logic [2:0]      out_second,
    output logic            out_last
);

    rbe_state_t       state_reg, state_next;
    logic [2:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    rbe_status_t      st_reg, st_next;

    logic       ov_reg, ov_next;
    logic [1:0] os_reg, os_next;
    logic       op_reg, op_next;
    logic [2:0] oa_reg, oa_next;
    logic [2:0] ob_reg, ob_next;
    logic       ol_reg, ol_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        st_reg  <= st_next;
        os_reg  <= os_next;
        op_reg  <= op_next;
        oa_reg  <= oa_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        st_next    = st_reg;
        slot_free  = !ov_reg || out_ready;
        ov_next    = ov_reg && !out_ready;
        os_next    = os_reg;
        op_next    = op_reg;
        oa_next    = oa_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        cmd.op     = DP_IDLE;
        cmd.idx    = i_reg[IDX_W-1:0];
        in_ready   = (state_reg == CS_IDLE);

        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op   = DP_CAPTURE;
                    idx_next = in_idx;
                    st_next  = ST_OK;
                    i_next   = '0;
                    case (rbe_mode_t'(in_mode))
                        MODE_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_BODIES))
                            begin
                                st_next    = ST_FULL;
                                state_next = CS_EMIT;
                            end
                            else
                                state_next = CS_ADD;
                        end
                        MODE_FORCE:
                        begin
                            if (CNT_W'(in_idx) >= count_reg)
                            begin
                                st_next    = ST_NOT_LOADED;
                                state_next = CS_EMIT;
                            end
                            else
                                state_next = CS_FORCE;
                        end
                        MODE_STEP:
                            state_next = (count_reg == '0) ? CS_EMIT : CS_I_LOAD;
                        default:
                            state_next = CS_EMIT;
                    endcase
                end
            end
            CS_ADD:
            begin
                cmd.op     = DP_ADD;
                cmd.idx    = count_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
                state_next = CS_EMIT;
            end
            CS_FORCE:
            begin
                cmd.op     = DP_FORCE;
                cmd.idx    = IDX_W'(idx_reg);
                state_next = CS_EMIT;
            end
            CS_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = st_reg;
                    op_next    = 1'b0;
                    oa_next    = '0;
                    ob_next    = '0;
                    ol_next    = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            CS_I_LOAD:
            begin
                cmd.op     = DP_LOAD;
                state_next = CS_I_CHK;
            end
            CS_I_CHK:
            begin
                if (stat.mass_pos)
                begin
                    cmd.op     = DP_DIV;
                    state_next = CS_I_DIV;
                end
                else if (i_reg + CNT_W'(1) == count_reg)
                begin
                    i_next     = '0;
                    state_next = (count_reg < CNT_W'(2)) ? CS_EMIT : CS_P_LOADI;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = CS_I_LOAD;
                end
            end
            CS_I_DIV:
            begin
                if (stat.div_done)
                    state_next = CS_I_MAX;
            end
            CS_I_MAX:
            begin
                cmd.op     = DP_MAX;
                state_next = CS_I_MAY;
            end
            CS_I_MAY:
            begin
                cmd.op     = DP_MAY;
                state_next = CS_I_MVX;
            end
            CS_I_MVX:
            begin
                cmd.op     = DP_MVX;
                state_next = CS_I_MVY;
            end
            CS_I_MVY:
            begin
                cmd.op     = DP_MVY;
                state_next = CS_I_PY;
            end
            CS_I_PY:
            begin
                cmd.op     = DP_PY;
                state_next = CS_I_WB;
            end
            CS_I_WB:
            begin
                cmd.op = DP_WB;
                if (i_reg + CNT_W'(1) == count_reg)
                begin
                    i_next     = '0;
                    state_next = (count_reg < CNT_W'(2)) ? CS_EMIT : CS_P_LOADI;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = CS_I_LOAD;
                end
            end
            CS_P_LOADI:
            begin
                cmd.op     = DP_LOADI;
                j_next     = i_reg + CNT_W'(1);
                state_next = CS_P_LOADJ;
            end
            CS_P_LOADJ:
            begin
                cmd.op     = DP_LOAD;
                cmd.idx    = j_reg[IDX_W-1:0];
                state_next = CS_P_TEST;
            end
            CS_P_TEST:
            begin
                if (!stat.hit || slot_free)
                begin
                    if (stat.hit)
                    begin
                        ov_next = 1'b1;
                        os_next = ST_OK;
                        op_next = 1'b1;
                        oa_next = i_reg[2:0];
                        ob_next = j_reg[2:0];
                        ol_next = 1'b0;
                    end
                    if (j_reg + CNT_W'(1) < count_reg)
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = CS_P_LOADJ;
                    end
                    else if (i_reg + CNT_W'(2) < count_reg)
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = CS_P_LOADI;
                    end
                    else
                        state_next = CS_EMIT;
                end
            end
            default:
                state_next = CS_IDLE;
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_pair   = op_reg;
    assign out_first  = oa_reg;
    assign out_second = ob_reg;
    assign out_last   = ol_reg;

endmodule
`default_nettype wire

/* sv/rbe_chk.sv */
// Port-level checker for the rigid body stepper, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none
module rbe_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);

    // A stalled result stays valid.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Pair results are ok and never close the run.
    a_pair_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == 2'd0) && !m_tlast)
        else $error("pair result malformed");

    // Pair indices are ordered.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata[2:0] < m_tdata[5:3]))
        else $error("pair indices not ordered");

    // Every non-pair result closes the item with zero indices.
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tlast && (m_tdata[5:0] == 6'd0))
        else $error("closing result malformed");

endmodule

bind rigid_body_euler_step_aabb_unit rbe_chk u_rbe_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
